/* rtl/seq_reorder_gap_request_macros.svh */
// Assertion macros for the sequence reorder block.
`ifndef SEQ_REORDER_GAP_REQUEST_MACROS_SVH
`define SEQ_REORDER_GAP_REQUEST_MACROS_SVH

// Property holds at every clock edge out of reset.
`define SRGR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define SRGR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/srgr_pkg.sv */
// Shared types and constants of the sequence reorder block.
package srgr_pkg;

  localparam int unsigned HOLD_DEPTH_DEF = 16;
  localparam int unsigned CFG_IDX_W      = 1;
  localparam int unsigned CFG_DATA_W     = 32;

  localparam logic [3:0]  THRESHOLD_RST = 4'd3;
  localparam logic [31:0] TIMEOUT_RST   = 32'd10000;
  localparam logic [31:0] EXPECTED_RST  = 32'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 1'd1;

  localparam logic MODE_MSG   = 1'b0;
  localparam logic MODE_CHECK = 1'b1;

  typedef enum logic [1:0] {
    KIND_DELIVER = 2'd0,
    KIND_GAP     = 2'd1,
    KIND_DROP    = 2'd2
  } kind_e;

  typedef struct packed {
    logic        mode;
    logic [31:0] seq;
    logic [15:0] msg_tag;
    logic [63:0] msg_version;
    logic        is_active;
    logic [47:0] time_ms;
  } in_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] out_seq;
    logic [15:0] out_tag;
    logic [31:0] gap_from;
    logic [31:0] gap_to;
    logic        last_of_run;
    logic [31:0] unread_total;
    logic [63:0] newest_version;
  } out_t;

  typedef struct packed {
    logic [31:0] seq;
    logic [15:0] tag;
    logic [63:0] version;
  } entry_t;

  typedef struct packed {
    logic eq;
    logic lt;
  } cmp_t;

endpackage

/* rtl/seq_reorder_gap_request.sv */
// Top level: sequencer, scan pipeline and result register of the reorder block.
//
//   channel | direction | handshake              | beat
//   in      | input     | in_valid_i/in_stall_o   | in_data_i (in_t)
//   out     | output    | out_valid_o/out_stall_i | out_data_o (out_t)
//   cfg     | input     | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// Scans walk the HOLD_DEPTH entries through the single read port, one per cycle;
// a chain scan stops at the successor it finds and restarts. A check or held message needs
// one scan; an in-order message with a run of R held successors needs R+1 scans.
// Reset empties the buffer at once through per-entry valid flags; no clearing pass.
// Output stalls hold the sequencer whenever a result waits to load; a held message
// also waits in its store step until the result register is free.
module seq_reorder_gap_request #(
  parameter int unsigned HOLD_DEPTH = srgr_pkg::HOLD_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  srgr_pkg::in_t                       in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output srgr_pkg::out_t                      out_data_o,
  input  logic                                cfg_we_i,
  input  logic [srgr_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [srgr_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import srgr_pkg::*;

  localparam int unsigned IW = $clog2(HOLD_DEPTH);
  localparam int unsigned CW = $clog2(HOLD_DEPTH + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(HOLD_DEPTH - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_MIN, S_TCHK, S_DUP, S_HOLD, S_CHAIN, S_LREAD, S_VREAD,
    S_VUPD, S_EMIT0, S_ELIST, S_EMEM, S_EOUT
  } state_e;

  state_e  state_q;
  in_t     in_q;
  out_t    out_q;
  logic    out_valid_q;

  logic [3:0]  thr_q;
  logic [31:0] timeout_q;
  logic [31:0] expected_q;
  logic [3:0]  ooo_q;
  logic [47:0] last_time_q;
  logic [63:0] ver_q;
  logic [31:0] unread_q;
  logic [HOLD_DEPTH-1:0] held_valid_q;

  logic [IW-1:0] ptr_q;
  logic          iss_done_q;
  logic          chk_q;
  logic [IW-1:0] chk_idx_q;
  logic          found_q;
  logic [31:0]   best_q;
  logic          dup_q;
  logic          free_ok_q;
  logic [IW-1:0] free_q;
  logic [31:0]   key_q;
  logic [CW-1:0] len_q;
  logic [CW-1:0] emit_q;

  logic [IW-1:0] list_mem [HOLD_DEPTH];
  logic [IW-1:0] list_rd_q;
  logic [IW-1:0] list_raddr;
  logic          list_we;

  logic          mem_we;
  logic [IW-1:0] mem_raddr;
  entry_t        mem_wdata;
  entry_t        rd_entry;

  logic [31:0] cmp_b;
  cmp_t        cmp;

  logic        out_free;
  logic        emit_en;
  out_t        emit_data;
  logic        scan_last;
  logic        entry_hit;
  logic [3:0]  cnt_inc;
  logic        drop;
  logic        gap_hit;
  logic [47:0] idle_ms;
  logic        time_ok;
  logic [32:0] unread_sum;
  logic [63:0] run_ver;

  logic        work_fire;
  logic        gap_beat;

  srgr_hold_mem #(.HOLD_DEPTH(HOLD_DEPTH)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (free_q),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (rd_entry)
  );

  srgr_cmp_unit u_cmp (
    .a_i   (rd_entry.seq),
    .b_i   (cmp_b),
    .res_o (cmp)
  );

  always_ff @(posedge clk_i) begin
    if (list_we) begin
      list_mem[len_q[IW-1:0]] <= chk_idx_q;
    end
    list_rd_q <= list_mem[list_raddr];
  end

  always_comb begin
    out_free   = !out_valid_q || !out_stall_i;
    scan_last  = chk_q && (chk_idx_q == LAST_IDX);
    entry_hit  = chk_q && held_valid_q[chk_idx_q];
    cnt_inc    = (ooo_q == 4'hF) ? ooo_q : ooo_q + 4'd1;
    drop       = dup_q || !free_ok_q;
    gap_hit    = !drop && (cnt_inc >= thr_q);
    idle_ms    = in_q.time_ms - last_time_q;
    time_ok    = (in_q.time_ms >= last_time_q) && (idle_ms > {16'd0, timeout_q});
    unread_sum = {1'b0, unread_q} + 33'(len_q) + 33'd1;
    run_ver    = (len_q == '0) ? in_q.msg_version : rd_entry.version;

    case (state_q)
      S_MIN:   cmp_b = best_q;
      S_DUP:   cmp_b = in_q.seq;
      default: cmp_b = key_q;
    endcase

    mem_raddr = ptr_q;
    case (state_q)
      S_VREAD, S_EMEM, S_EOUT: mem_raddr = list_rd_q;
      default:                 mem_raddr = ptr_q;
    endcase

    list_raddr = (state_q == S_LREAD) ? IW'(len_q - CW'(1)) : emit_q[IW-1:0];
    list_we    = (state_q == S_CHAIN) && entry_hit && cmp.eq;

    mem_we            = (state_q == S_HOLD) && out_free && !drop;
    mem_wdata.seq     = in_q.seq;
    mem_wdata.tag     = in_q.msg_tag;
    mem_wdata.version = in_q.msg_version;

    emit_en                  = 1'b0;
    emit_data.kind           = KIND_DELIVER;
    emit_data.out_seq        = '0;
    emit_data.out_tag        = '0;
    emit_data.gap_from       = '0;
    emit_data.gap_to         = '0;
    emit_data.last_of_run    = 1'b1;
    emit_data.unread_total   = unread_q;
    emit_data.newest_version = ver_q;
    case (state_q)
      S_TCHK: begin
        emit_en            = out_free && found_q && time_ok;
        emit_data.kind     = KIND_GAP;
        emit_data.gap_from = expected_q;
        emit_data.gap_to   = best_q - 32'd1;
      end
      S_HOLD: begin
        emit_en = out_free && (drop || gap_hit);
        if (drop) begin
          emit_data.kind    = KIND_DROP;
          emit_data.out_seq = in_q.seq;
          emit_data.out_tag = in_q.msg_tag;
        end else begin
          emit_data.kind     = KIND_GAP;
          emit_data.gap_from = expected_q;
          emit_data.gap_to   = in_q.seq - 32'd1;
        end
      end
      S_EMIT0: begin
        emit_en               = out_free;
        emit_data.out_seq     = in_q.seq;
        emit_data.out_tag     = in_q.msg_tag;
        emit_data.last_of_run = (len_q == '0);
      end
      S_EOUT: begin
        emit_en               = out_free;
        emit_data.out_seq     = rd_entry.seq;
        emit_data.out_tag     = rd_entry.tag;
        emit_data.last_of_run = (emit_q == len_q - CW'(1));
      end
      default: emit_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      thr_q        <= THRESHOLD_RST;
      timeout_q    <= TIMEOUT_RST;
      expected_q   <= EXPECTED_RST;
      ooo_q        <= '0;
      last_time_q  <= '0;
      ver_q        <= '0;
      unread_q     <= '0;
      held_valid_q <= '0;
      ptr_q        <= '0;
      iss_done_q   <= 1'b0;
      chk_q        <= 1'b0;
      chk_idx_q    <= '0;
      found_q      <= 1'b0;
      dup_q        <= 1'b0;
      free_ok_q    <= 1'b0;
      free_q       <= '0;
      len_q        <= '0;
      emit_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_THRESHOLD: thr_q     <= cfg_data_i[3:0];
          CFG_TIMEOUT:   timeout_q <= cfg_data_i;
          default:       thr_q     <= thr_q;
        endcase
      end

      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (emit_en) begin
        out_valid_q <= 1'b1;
        out_q       <= emit_data;
      end

      // scan pipeline: issue one entry per cycle, compare it the next
      if (state_q == S_MIN || state_q == S_DUP || state_q == S_CHAIN) begin
        if (!iss_done_q) begin
          chk_q     <= 1'b1;
          chk_idx_q <= ptr_q;
          if (ptr_q == LAST_IDX) begin
            iss_done_q <= 1'b1;
          end else begin
            ptr_q <= ptr_q + IW'(1);
          end
        end else begin
          chk_q <= 1'b0;
        end
      end

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            in_q       <= in_data_i;
            ptr_q      <= '0;
            iss_done_q <= 1'b0;
            chk_q      <= 1'b0;
            found_q    <= 1'b0;
            dup_q      <= 1'b0;
            free_ok_q  <= 1'b0;
            len_q      <= '0;
            key_q      <= in_data_i.seq + 32'd1;
            if (in_data_i.mode == MODE_CHECK) begin
              state_q <= S_MIN;
            end else if (in_data_i.seq > expected_q) begin
              state_q <= S_DUP;
            end else if (in_data_i.seq == expected_q) begin
              state_q <= S_CHAIN;
            end
          end
        end
        S_MIN: begin
          if (entry_hit && (!found_q || cmp.lt)) begin
            found_q <= 1'b1;
            best_q  <= rd_entry.seq;
          end
          if (scan_last) begin
            state_q <= S_TCHK;
          end
        end
        S_TCHK: begin
          if (!(found_q && time_ok)) begin
            state_q <= S_IDLE;
          end else if (out_free) begin
            last_time_q <= in_q.time_ms;
            state_q     <= S_IDLE;
          end
        end
        S_DUP: begin
          if (entry_hit && cmp.eq) begin
            dup_q <= 1'b1;
          end
          if (chk_q && !held_valid_q[chk_idx_q] && !free_ok_q) begin
            free_ok_q <= 1'b1;
            free_q    <= chk_idx_q;
          end
          if (scan_last) begin
            state_q <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            if (!drop) begin
              held_valid_q[free_q] <= 1'b1;
              ooo_q                <= gap_hit ? 4'd0 : cnt_inc;
            end
            state_q <= S_IDLE;
          end
        end
        S_CHAIN: begin
          if (entry_hit && cmp.eq) begin
            // successor found: record it and rescan for the next one
            len_q      <= len_q + CW'(1);
            key_q      <= key_q + 32'd1;
            ptr_q      <= '0;
            iss_done_q <= 1'b0;
            chk_q      <= 1'b0;
          end else if (scan_last) begin
            state_q <= S_LREAD;
          end
        end
        S_LREAD: state_q <= S_VREAD;
        S_VREAD: state_q <= S_VUPD;
        S_VUPD: begin
          if (run_ver > ver_q) begin
            ver_q <= run_ver;
          end
          if (!in_q.is_active) begin
            unread_q <= unread_sum[32] ? 32'hFFFF_FFFF : unread_sum[31:0];
          end
          expected_q  <= key_q;
          ooo_q       <= '0;
          last_time_q <= in_q.time_ms;
          emit_q      <= '0;
          state_q     <= S_EMIT0;
        end
        S_EMIT0: begin
          if (out_free) begin
            state_q <= (len_q == '0) ? S_IDLE : S_ELIST;
          end
        end
        S_ELIST: state_q <= S_EMEM;
        S_EMEM:  state_q <= S_EOUT;
        S_EOUT: begin
          if (out_free) begin
            held_valid_q[list_rd_q] <= 1'b0;
            emit_q                  <= emit_q + CW'(1);
            state_q <= (emit_q == len_q - CW'(1)) ? S_IDLE : S_ELIST;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // an old message is dropped at the accept edge and leaves the block idle
  assign work_fire = in_valid_i && !in_stall_o &&
                     ((in_data_i.mode == MODE_CHECK) || (in_data_i.seq >= expected_q));
  assign gap_beat  = out_valid_o && (out_data_o.kind == KIND_GAP);

`include "seq_reorder_gap_request_macros.svh"

  `SRGR_ASSERT_NEXT(a_busy_after_accept, work_fire, in_stall_o, "block idle after accept")
  `SRGR_ASSERT(a_gap_no_seq, !gap_beat || out_data_o.out_seq == '0, "gap beat carries a seq")
  `SRGR_ASSERT(a_run_bounded, len_q <= CW'(HOLD_DEPTH), "run longer than the buffer")

endmodule

/* rtl/srgr_hold_mem.sv */
// Held-message store: one write port, one registered read port.
module srgr_hold_mem #(
  parameter int unsigned HOLD_DEPTH = srgr_pkg::HOLD_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [$clog2(HOLD_DEPTH)-1:0] waddr_i,
  input  srgr_pkg::entry_t              wdata_i,
  input  logic [$clog2(HOLD_DEPTH)-1:0] raddr_i,
  output srgr_pkg::entry_t              rdata_o
);
  import srgr_pkg::*;

  entry_t mem_q [HOLD_DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/srgr_cmp_unit.sv */
// Shared sequence comparator used by every buffer scan.
module srgr_cmp_unit (
  input  logic [31:0]    a_i,
  input  logic [31:0]    b_i,
  output srgr_pkg::cmp_t res_o
);
  import srgr_pkg::*;

  always_comb begin
    res_o.eq = (a_i == b_i);
    res_o.lt = (a_i < b_i);
  end

endmodule
